// ===== src/bgs_pkg.sv =====
// ----------------------------------------------------------------------------
// bgs_pkg: shared types and constants of the BMP grayscale stream
//
// Holds the beat payload structs of both channels, the header layout of a
// 24-bit bitmap file, the register indexes and the reset luma weights.
// ----------------------------------------------------------------------------
package bgs_pkg;

   // Header layout of a 24-bit bitmap file.
   localparam int unsigned HEADER_BYTES = 54;
   localparam int unsigned HDR_IDX_W    = 6;
   localparam logic [HDR_IDX_W-1:0] HDR_LAST     = HDR_IDX_W'(HEADER_BYTES - 1);
   localparam logic [HDR_IDX_W-1:0] WIDTH_FIRST  = 6'd18;
   localparam logic [HDR_IDX_W-1:0] WIDTH_LAST   = 6'd21;
   localparam logic [HDR_IDX_W-1:0] HEIGHT_FIRST = 6'd22;
   localparam logic [HDR_IDX_W-1:0] HEIGHT_LAST  = 6'd25;

   // Pixel byte order inside one pixel.
   localparam logic [1:0] PHASE_BLUE  = 2'd0;
   localparam logic [1:0] PHASE_GREEN = 2'd1;
   localparam logic [1:0] PHASE_RED   = 2'd2;

   // Configuration registers.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_RED   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_GREEN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_BLUE  = 2'd2;

   localparam logic [7:0] WEIGHT_RED_RESET   = 8'd54;
   localparam logic [7:0] WEIGHT_GREEN_RESET = 8'd184;
   localparam logic [7:0] WEIGHT_BLUE_RESET  = 8'd18;

   // Number of output beats a luma pixel expands to.
   localparam logic [1:0] LUMA_COPIES = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       start_of_file;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_payload_type;

endpackage

// ===== src/bmp_grayscale_stream_top.sv =====
// ----------------------------------------------------------------------------
// bmp_grayscale_stream_top: 24-bit bitmap to grayscale byte stream
//
// Parses the header, converts each BGR pixel to three equal luma bytes,
// passes header and row padding bytes unchanged, drops bytes after the image.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries the file one byte per beat; start_of_file marks
//   the first byte of a new file and restarts header parsing. The rsp
//   channel returns the transformed file; last is set on the final beat
//   caused by one input byte. The csr port sets the three luma weights; the
//   user must write it only while the block is idle; this is not enforced.
// Data path and throughput:
//   An input byte that produces output is registered in the middle stage,
//   then in the output register, which offers it on the rsp port. Without
//   rsp stalls one byte is taken every cycle but for the case below: the red
//   byte of a pixel expands into three output beats, which the single output
//   register sends one per cycle while the next pixel's blue and green bytes
//   are taken in. A header or padding byte that follows a pixel waits in the
//   middle stage, holding req_stall until the last copy leaves.
//   Dropped bytes (after the last row) are accepted without producing output.
// Reset and stall:
//   Reset empties both stages, clears the parser and restores the weights.
//   When the receiver stalls, the output register holds its beat and the
//   stall backs up through the middle stage to req_stall.
// ----------------------------------------------------------------------------
module bmp_grayscale_stream_top
   import bgs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Luma weights.
   logic [7:0] weight_red_ff, weight_green_ff, weight_blue_ff;

   // Parser state.
   logic [HDR_IDX_W-1:0] header_index_ff, header_index_in;
   logic [31:0] image_width_ff, image_width_in;
   logic [31:0] image_height_ff, image_height_in;
   logic [1:0]  byte_phase_ff, byte_phase_in;
   logic [7:0]  held_blue_ff, held_blue_in;
   logic [7:0]  held_green_ff, held_green_in;
   logic [31:0] column_count_ff, column_count_in;
   logic [1:0]  pad_count_ff, pad_count_in;
   logic [31:0] row_count_ff, row_count_in;
   logic        image_done_ff, image_done_in;

   // Middle stage: one pending result, either a passed byte or a pixel.
   logic        mid_valid_ff;
   logic        mid_luma_ff, mid_luma_in;
   logic [7:0]  mid_byte_ff, mid_byte_in;
   logic [7:0]  mid_blue_ff, mid_blue_in;
   logic [7:0]  mid_green_ff, mid_green_in;
   logic        mid_load;

   // Output register: beats still to send of the current result.
   logic [1:0]  out_count_ff;
   logic [7:0]  out_byte_ff;

   logic        req_accept, rsp_accept, out_free, mid_move;
   logic [17:0] luma_sum;
   logic [7:0]  luma_sat;

   // Handshake.
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign out_free   = (out_count_ff == 2'd0) || (out_count_ff == 2'd1 && !rsp_stall);
   assign mid_move   = mid_valid_ff && out_free;
   assign req_stall  = mid_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid            = (out_count_ff != 2'd0);
   assign rsp_payload.out_byte = out_byte_ff;
   assign rsp_payload.last     = (out_count_ff == 2'd1);

   // Weight registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_red_ff   <= WEIGHT_RED_RESET;
         weight_green_ff <= WEIGHT_GREEN_RESET;
         weight_blue_ff  <= WEIGHT_BLUE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WEIGHT_RED:   weight_red_ff   <= csr_data;
            CSR_WEIGHT_GREEN: weight_green_ff <= csr_data;
            CSR_WEIGHT_BLUE:  weight_blue_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Parser: next state for an accepted byte and the result it produces.
   always_comb begin
      logic [7:0]  b;
      logic [1:0]  lane;
      logic [31:0] col_next;
      logic [31:0] row_next;
      b    = req_payload.in_byte;
      lane = header_index_ff[1:0] - 2'd2;

      header_index_in = header_index_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      byte_phase_in   = byte_phase_ff;
      held_blue_in    = held_blue_ff;
      held_green_in   = held_green_ff;
      column_count_in = column_count_ff;
      pad_count_in    = pad_count_ff;
      row_count_in    = row_count_ff;
      image_done_in   = image_done_ff;

      // A start mark returns the parser to its reset state first.
      if (req_payload.start_of_file) begin
         header_index_in = '0;
         image_width_in  = '0;
         image_height_in = '0;
         byte_phase_in   = PHASE_BLUE;
         held_blue_in    = '0;
         held_green_in   = '0;
         column_count_in = '0;
         pad_count_in    = '0;
         row_count_in    = '0;
         image_done_in   = 1'b0;
         lane            = 2'd0;
      end

      mid_load     = 1'b0;
      mid_luma_in  = 1'b0;
      mid_byte_in  = b;
      mid_blue_in  = held_blue_in;
      mid_green_in = held_green_in;
      row_next     = row_count_in + 32'd1;
      col_next     = column_count_in + 32'd1;

      if (header_index_in <= HDR_LAST) begin
         // Header byte: capture the dimensions and pass the byte through.
         if (header_index_in >= WIDTH_FIRST && header_index_in <= WIDTH_LAST) begin
            image_width_in[{lane, 3'b000} +: 8] = b;
         end else if (header_index_in >= HEIGHT_FIRST &&
                      header_index_in <= HEIGHT_LAST) begin
            image_height_in[{lane, 3'b000} +: 8] = b;
         end
         if (header_index_in == HDR_LAST &&
             (image_width_in == 32'd0 || image_height_in == 32'd0)) begin
            image_done_in = 1'b1;
         end
         header_index_in = header_index_in + 1'b1;
         mid_load        = 1'b1;
      end else if (image_done_in) begin
         // Bytes after the image are dropped.
         mid_load = 1'b0;
      end else if (pad_count_in != 2'd0) begin
         // Row padding passes through; the last one closes the row.
         pad_count_in = pad_count_in - 2'd1;
         if (pad_count_in == 2'd0) begin
            column_count_in = '0;
            row_count_in    = row_next;
            if (row_next == image_height_in) begin
               image_done_in = 1'b1;
            end
         end
         mid_load = 1'b1;
      end else if (byte_phase_in == PHASE_BLUE) begin
         held_blue_in  = b;
         byte_phase_in = PHASE_GREEN;
      end else if (byte_phase_in == PHASE_GREEN) begin
         held_green_in = b;
         byte_phase_in = PHASE_RED;
      end else begin
         // Red byte completes a pixel.
         byte_phase_in   = PHASE_BLUE;
         column_count_in = col_next;
         if (col_next == image_width_in) begin
            pad_count_in = image_width_in[1:0];
            if (image_width_in[1:0] == 2'd0) begin
               column_count_in = '0;
               row_count_in    = row_next;
               if (row_next == image_height_in) begin
                  image_done_in = 1'b1;
               end
            end
         end
         mid_load    = 1'b1;
         mid_luma_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_index_ff <= '0;
         image_width_ff  <= '0;
         image_height_ff <= '0;
         byte_phase_ff   <= PHASE_BLUE;
         held_blue_ff    <= '0;
         held_green_ff   <= '0;
         column_count_ff <= '0;
         pad_count_ff    <= '0;
         row_count_ff    <= '0;
         image_done_ff   <= 1'b0;
      end else if (req_accept) begin
         header_index_ff <= header_index_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         byte_phase_ff   <= byte_phase_in;
         held_blue_ff    <= held_blue_in;
         held_green_ff   <= held_green_in;
         column_count_ff <= column_count_in;
         pad_count_ff    <= pad_count_in;
         row_count_ff    <= row_count_in;
         image_done_ff   <= image_done_in;
      end
   end

   // Middle stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (req_accept) begin
         mid_valid_ff <= mid_load;
      end else if (mid_move) begin
         mid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && mid_load) begin
         mid_luma_ff  <= mid_luma_in;
         mid_byte_ff  <= mid_byte_in;
         mid_blue_ff  <= mid_blue_in;
         mid_green_ff <= mid_green_in;
      end
   end

   // Weighted luma, truncated to whole units and saturated.
   assign luma_sum = 18'(weight_red_ff * mid_byte_ff)
                   + 18'(weight_green_ff * mid_green_ff)
                   + 18'(weight_blue_ff * mid_blue_ff);
   assign luma_sat = (luma_sum[17:16] != 2'd0) ? 8'hFF : luma_sum[15:8];

   // Output register: a pixel is sent three times, other bytes once.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_count_ff <= 2'd0;
      end else if (mid_move) begin
         out_count_ff <= mid_luma_ff ? LUMA_COPIES : 2'd1;
      end else if (rsp_accept) begin
         out_count_ff <= out_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_move) begin
         out_byte_ff <= mid_luma_ff ? luma_sat : mid_byte_ff;
      end
   end

   // A result entering the output register sets one beat or three.
   assert property (@(posedge clock) disable iff (reset)
      mid_move |=> (out_count_ff == 2'd1 || out_count_ff == LUMA_COPIES))
      else $error("output count not loaded with one or three beats");

   // Copies of one pixel keep the same byte.
   assert property (@(posedge clock) disable iff (reset)
      (out_count_ff == 2'd2 || out_count_ff == 2'd3) |=> $stable(out_byte_ff))
      else $error("luma byte changed between copies");

   // Input is held back while the middle stage is full and more than one beat waits.
   assert property (@(posedge clock) disable iff (reset)
      (mid_valid_ff && (out_count_ff == 2'd2 || out_count_ff == 2'd3)) |-> req_stall)
      else $error("input accepted while output register is busy");

   // The pixel phase never takes its unused code.
   assert property (@(posedge clock) disable iff (reset)
      byte_phase_ff != 2'd3)
      else $error("pixel byte phase out of range");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bmp_grayscale_stream_top
//
// Feeds bitmap files one byte per beat with random idle and stall gaps.
// The files include well-formed small images, zero-size images, huge
// dimensions cut short and broken headers. A scoreboard class predicts
// every output beat from the accepted input beats and the luma weights,
// and checks each output beat in order against that prediction.
// ----------------------------------------------------------------------------
module testbench;
   import bgs_pkg::*;

   // Register index with no register behind it; writes to it are ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   // Cut length that never truncates a file.
   localparam int NO_CUT = 1 << 30;
   // Input beats the whole run aims at; each idling phase raises the running target by a quarter.
   localparam int ITEM_GOAL = 410;

   // Predicts the grayscale stream and checks output beats against it.
   class grayscale_scoreboard;
      logic [7:0]           weight_r;
      logic [7:0]           weight_g;
      logic [7:0]           weight_b;
      logic [HDR_IDX_W-1:0] header_count;
      logic [31:0]          img_width;
      logic [31:0]          img_height;
      logic [1:0]           pixel_phase;
      logic [7:0]           hold_blue;
      logic [7:0]           hold_green;
      logic [31:0]          col_count;
      logic [1:0]           pad_left;
      logic [31:0]          rows_done;
      logic                 image_over;
      rsp_payload_type      expected_beats[$];
      int                   mismatch_count;

      function new();
         weight_r = WEIGHT_RED_RESET;
         weight_g = WEIGHT_GREEN_RESET;
         weight_b = WEIGHT_BLUE_RESET;
         mismatch_count = 0;
         clear_parser();
      endfunction

      // Parser state after reset or a start-of-file mark; weights are kept.
      function void clear_parser();
         header_count = '0;
         img_width    = '0;
         img_height   = '0;
         pixel_phase  = PHASE_BLUE;
         hold_blue    = '0;
         hold_green   = '0;
         col_count    = '0;
         pad_left     = '0;
         rows_done    = '0;
         image_over   = 1'b0;
      endfunction

      function void set_weight(logic [CSR_INDEX_W-1:0] idx, logic [7:0] data);
         case (idx)
            CSR_WEIGHT_RED:   weight_r = data;
            CSR_WEIGHT_GREEN: weight_g = data;
            CSR_WEIGHT_BLUE:  weight_b = data;
            default: ;
         endcase
      endfunction

      function void end_row();
         col_count = '0;
         rows_done = rows_done + 1;
         if (rows_done == img_height) image_over = 1'b1;
      endfunction

      // Works out the output beats that one accepted input beat causes.
      function void note_byte(req_payload_type beat);
         logic [7:0]  b;
         logic [17:0] weighted;
         logic [9:0]  scaled;
         logic [7:0]  luma;
         b = beat.in_byte;
         if (beat.start_of_file) clear_parser();

         // Header bytes pass through; width and height are little endian.
         if (header_count < HEADER_BYTES) begin
            if (header_count >= WIDTH_FIRST && header_count <= WIDTH_LAST)
               img_width |= 32'(b) << (8 * (header_count - WIDTH_FIRST));
            else if (header_count >= HEIGHT_FIRST && header_count <= HEIGHT_LAST)
               img_height |= 32'(b) << (8 * (header_count - HEIGHT_FIRST));
            header_count = header_count + 1'b1;
            if (header_count == HEADER_BYTES && (img_width == 0 || img_height == 0))
               image_over = 1'b1;
            expected_beats.push_back('{out_byte: b, last: 1'b1});
            return;
         end

         // Everything after the last row is dropped.
         if (image_over) return;

         // Row padding passes through and closes the row on its last byte.
         if (pad_left != 0) begin
            pad_left = pad_left - 2'd1;
            if (pad_left == 0) end_row();
            expected_beats.push_back('{out_byte: b, last: 1'b1});
            return;
         end

         case (pixel_phase)
            PHASE_BLUE: begin
               hold_blue   = b;
               pixel_phase = PHASE_GREEN;
            end
            PHASE_GREEN: begin
               hold_green  = b;
               pixel_phase = PHASE_RED;
            end
            default: begin
               // Truncated Q10.8 luma, saturated to one byte.
               pixel_phase = PHASE_BLUE;
               weighted = weight_r * b + weight_g * hold_green + weight_b * hold_blue;
               scaled = weighted[17:8];
               luma = (scaled > 10'd255) ? 8'hFF : scaled[7:0];
               col_count = col_count + 1;
               if (col_count == img_width) begin
                  pad_left = img_width[1:0];
                  if (pad_left == 0) end_row();
               end
               for (int i = 0; i < LUMA_COPIES; i++)
                  expected_beats.push_back('{out_byte: luma, last: (i == LUMA_COPIES - 1)});
            end
         endcase
      endfunction

      // Compares one output beat with the oldest expected beat.
      function void check_beat(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_beats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected beat out_byte %02h last %0b",
                        $time, got.out_byte, got.last);
            return;
         end
         want = expected_beats.pop_front();
         if (got.out_byte !== want.out_byte || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: beat mismatch out_byte exp %02h got %02h, last exp %0b got %0b",
                        $time, want.out_byte, got.out_byte, want.last, got.last);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall    = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_data     = '0;

   grayscale_scoreboard sb;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int counted_items = 0;

   bmp_grayscale_stream_top u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver side stalls at random in the phases that ask for it.
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // Every accepted beat on either channel goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_byte(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_beat(rsp_payload);
      end
   end

   // Byte values leaning toward the extremes.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Offers one beat, with random idle cycles first, and waits until taken.
   task automatic send_byte(input logic [7:0] value, input logic mark);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{in_byte: value, start_of_file: mark};
      do @(posedge clock); while (req_stall);
      counted_items++;
   endtask

   // Sends a file of the given size, cut after a number of bytes, followed
   // by tail bytes that land after the image and are dropped.
   task automatic send_file(input logic [31:0] w, input logic [31:0] h,
                            input logic mark, input int cut, input int tail);
      logic [7:0]        hdr [HEADER_BYTES];
      longint unsigned   total;
      for (int j = 0; j < HEADER_BYTES; j++) hdr[j] = pick_byte();
      for (int j = 0; j < 4; j++) begin
         hdr[WIDTH_FIRST + j]  = w[8*j +: 8];
         hdr[HEIGHT_FIRST + j] = h[8*j +: 8];
      end
      total = HEADER_BYTES + 64'(h) * (64'(w) * 3 + 64'(w[1:0]));
      for (longint k = 0; k < total && k < cut; k++)
         send_byte((k < HEADER_BYTES) ? hdr[k] : pick_byte(), mark && (k == 0));
      repeat (tail) send_byte(pick_byte(), 1'b0);
   endtask

   // Picks one file shape: mostly well-formed small images.
   task automatic random_file();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70)
         send_file($urandom_range(1, 5), $urandom_range(1, 3), 1'b1, NO_CUT,
                   $urandom_range(0, 3));
      else if (pick < 80) begin
         if ($urandom_range(1))
            send_file(0, $urandom, 1'b1, NO_CUT, $urandom_range(1, 3));
         else
            send_file($urandom, 0, 1'b1, NO_CUT, $urandom_range(1, 3));
      end else if (pick < 90)
         send_file($urandom, $urandom, 1'b1, HEADER_BYTES + $urandom_range(0, 30), 0);
      else
         send_file($urandom_range(1, 5), $urandom_range(1, 3), 1'b1,
                   $urandom_range(1, HEADER_BYTES - 1), 0);
   endtask

   // Lets the block drain so that registers can be written safely.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(posedge clock);
      sb.set_weight(idx, data);
   endtask

   task automatic write_weights(input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic spare);
      write_reg(CSR_WEIGHT_RED, r);
      write_reg(CSR_WEIGHT_GREEN, g);
      write_reg(CSR_WEIGHT_BLUE, b);
      if (spare) write_reg(CSR_SPARE, pick_byte());
      csr_write_en <= 1'b0;
   endtask

   // Main sequence: directed files, then random files in each idling phase.
   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset weights on a file with no start mark, then a zero-width file.
      send_file(1, 1, 1'b0, NO_CUT, 2);
      send_file(0, 2, 1'b1, NO_CUT, 2);
      settle();

      // Each phase sends at least one file; the spare index changes nothing.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 78; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 78; end
            default: begin send_idle_pct = 12; stall_pct = 12; end
         endcase
         write_weights(pick_byte(), pick_byte(), pick_byte(), 1'b1);
         do random_file(); while (counted_items < ITEM_GOAL * (phase + 1) / 4);
         settle();
      end

      if (sb.expected_beats.size() != 0)
         $display("%0d expected beats never arrived", sb.expected_beats.size());
      if (sb.mismatch_count == 0 && sb.expected_beats.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Hard stop far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
